/* rtl/mrpasm_pkg.sv */
// Types and constants shared by the MRP attribute state machine modules.
package mrpasm_pkg;

  localparam int unsigned LEAVE_W        = 10;
  localparam int unsigned CMD_W          = 5;
  localparam int unsigned INDEX_W        = 5;
  localparam logic [LEAVE_W-1:0] LEAVE_PERIOD_RST = 10'd100;

  typedef enum logic [CMD_W-1:0] {
    CMD_BEGIN      = 5'd0,
    CMD_NEW        = 5'd1,
    CMD_JOIN       = 5'd2,
    CMD_LV         = 5'd3,
    CMD_RNEW       = 5'd4,
    CMD_RJOININ    = 5'd5,
    CMD_RIN        = 5'd6,
    CMD_RJOINMT    = 5'd7,
    CMD_RMT        = 5'd8,
    CMD_RLV        = 5'd9,
    CMD_RLA        = 5'd10,
    CMD_REDECLARE  = 5'd11,
    CMD_PERIODIC   = 5'd12,
    CMD_TX         = 5'd13,
    CMD_TXLA       = 5'd14,
    CMD_FLUSH      = 5'd15,
    CMD_LEAVETIMER = 5'd16,
    CMD_TICK       = 5'd17
  } cmd_e;

  typedef enum logic [3:0] {
    APP_VO = 4'd0,
    APP_VP = 4'd1,
    APP_VN = 4'd2,
    APP_AN = 4'd3,
    APP_AA = 4'd4,
    APP_QA = 4'd5,
    APP_LA = 4'd6,
    APP_AO = 4'd7,
    APP_QO = 4'd8,
    APP_AP = 4'd9,
    APP_QP = 4'd10,
    APP_LO = 4'd11
  } app_e;

  typedef enum logic [1:0] {
    REG_IN = 2'd0,
    REG_LV = 2'd1,
    REG_MT = 2'd2
  } reg_e;

  typedef enum logic [2:0] {
    EV_NEW    = 3'd0,
    EV_JOININ = 3'd1,
    EV_IN     = 3'd2,
    EV_JOINMT = 3'd3,
    EV_MT     = 3'd4,
    EV_LV     = 3'd5
  } txev_e;

  // One attribute entry as stored in the table
  typedef struct packed {
    logic               leave_active;
    logic [LEAVE_W-1:0] leave_count;
    reg_e               registrar;
    app_e               applicant;
  } entry_t;

  // Per-event result of the update logic
  typedef struct packed {
    app_e  applicant;
    reg_e  registrar;
    logic  tx_valid;
    txev_e tx_attr;
    logic  join_ind;
    logic  join_is_new;
  } res_t;

  localparam entry_t ENTRY_RST = '{
    leave_active: 1'b0,
    leave_count:  '0,
    registrar:    REG_MT,
    applicant:    APP_VO
  };

endpackage

/* rtl/mrp_attribute_state_machine.sv */
// Result: taking start moves the state to update, and the strobe register is set as that state ends.
// A new event is not taken while the previous one is in flight: the entry memory is read,
// then the updated entry is written back, and busy is high during that write-back.
// Reset: every entry reads as applicant VO, registrar MT, leave timer stopped at once
// (per-entry valid bits, no clearing pass); leave_period returns to 100.
// Results cannot be stalled by the receiver.
module mrp_attribute_state_machine #(
  parameter int unsigned ENTRIES = 32
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // event channel
  input  logic                                   start,
  output logic                                   busy,
  input  logic [mrpasm_pkg::CMD_W-1:0]           cmd_i,
  input  logic [mrpasm_pkg::INDEX_W-1:0]         entry_index_i,
  // result channel
  output logic                                   result_strobe_o,
  output logic [3:0]                             applicant_now_o,
  output logic [1:0]                             registrar_now_o,
  output logic                                   tx_valid_o,
  output logic [2:0]                             tx_attr_o,
  output logic                                   join_ind_o,
  output logic                                   join_is_new_o,
  output logic [mrpasm_pkg::INDEX_W-1:0]         entry_echo_o,
  // configuration channel
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [mrpasm_pkg::LEAVE_W-1:0]         cfg_data_i
);

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [8:0]  ENTRIES_L = 9'(ENTRIES);

  typedef enum logic {
    ST_IDLE,
    ST_UPDATE
  } state_e;

  state_e                          state_q;
  logic                            accept;
  logic                            in_range;
  logic [IDX_W-1:0]                rd_addr;
  logic [IDX_W-1:0]                addr_q;
  logic [mrpasm_pkg::CMD_W-1:0]    cmd_q;
  logic [mrpasm_pkg::INDEX_W-1:0]  index_q;
  logic                            hit_q;
  logic [mrpasm_pkg::LEAVE_W-1:0]  leave_period_q;
  logic                            wr_en;
  mrpasm_pkg::entry_t              cur_entry;
  mrpasm_pkg::entry_t              nxt_entry;
  mrpasm_pkg::res_t                res;
  mrpasm_pkg::res_t                res_q;
  logic                            strobe_q;
  logic [mrpasm_pkg::INDEX_W-1:0]  echo_q;

  assign busy        = (state_q == ST_UPDATE);
  assign accept      = start && !busy;
  assign in_range    = {4'b0000, entry_index_i} < ENTRIES_L;
  assign rd_addr     = IDX_W'(entry_index_i);
  assign wr_en       = (state_q == ST_UPDATE) && hit_q;
  assign cfg_ready_o = 1'b1;

  // Hold the leave period register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      leave_period_q <= mrpasm_pkg::LEAVE_PERIOD_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      leave_period_q <= cfg_data_i;
    end
  end

  mrpasm_table #(
    .ENTRIES (ENTRIES)
  ) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept && in_range),
    .rd_addr_i (rd_addr),
    .rd_data_o (cur_entry),
    .wr_en_i   (wr_en),
    .wr_addr_i (addr_q),
    .wr_data_i (nxt_entry)
  );

  mrpasm_update u_update (
    .cmd_i          (cmd_q),
    .cur_i          (cur_entry),
    .leave_period_i (leave_period_q),
    .nxt_o          (nxt_entry),
    .res_o          (res)
  );

  // Sequence read then write-back, and register the result beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      strobe_q <= 1'b0;
      cmd_q    <= '0;
      index_q  <= '0;
      addr_q   <= '0;
      hit_q    <= 1'b0;
      echo_q   <= '0;
      res_q    <= '{applicant: mrpasm_pkg::APP_VO, registrar: mrpasm_pkg::REG_MT,
                    tx_valid: 1'b0, tx_attr: mrpasm_pkg::EV_NEW,
                    join_ind: 1'b0, join_is_new: 1'b0};
    end else begin
      strobe_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            cmd_q   <= cmd_i;
            index_q <= entry_index_i;
            addr_q  <= rd_addr;
            hit_q   <= in_range;
            state_q <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          strobe_q <= 1'b1;
          echo_q   <= index_q;
          if (hit_q) begin
            res_q <= res;
          end else begin
            res_q <= '{applicant: mrpasm_pkg::APP_VO, registrar: mrpasm_pkg::REG_MT,
                        tx_valid: 1'b0, tx_attr: mrpasm_pkg::EV_NEW,
                        join_ind: 1'b0, join_is_new: 1'b0};
          end
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign result_strobe_o = strobe_q;
  assign applicant_now_o = res_q.applicant;
  assign registrar_now_o = res_q.registrar;
  assign tx_valid_o      = res_q.tx_valid;
  assign tx_attr_o       = res_q.tx_attr;
  assign join_ind_o      = res_q.join_ind;
  assign join_is_new_o   = res_q.join_is_new;
  assign entry_echo_o    = echo_q;

endmodule

/* rtl/mrpasm_table.sv */
// Attribute entry memory: one synchronous read port, one write port, per-entry valid bits.
module mrpasm_table #(
  parameter int unsigned ENTRIES = 32
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     rd_en_i,
  input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] rd_addr_i,
  output mrpasm_pkg::entry_t                       rd_data_o,
  input  logic                                     wr_en_i,
  input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] wr_addr_i,
  input  mrpasm_pkg::entry_t                       wr_data_i
);

  mrpasm_pkg::entry_t mem_q [ENTRIES];
  mrpasm_pkg::entry_t rd_data_q;
  logic [ENTRIES-1:0] valid_q;
  logic               rd_valid_q;

  // Write port and registered read data
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  // Track written entries; unwritten ones read as the reset entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_data_q : mrpasm_pkg::ENTRY_RST;

endmodule

/* rtl/mrpasm_update.sv */
// Registrar, applicant and leave timer next-state logic for one entry.
module mrpasm_update (
  input  logic [mrpasm_pkg::CMD_W-1:0]   cmd_i,
  input  mrpasm_pkg::entry_t             cur_i,
  input  logic [mrpasm_pkg::LEAVE_W-1:0] leave_period_i,
  output mrpasm_pkg::entry_t             nxt_o,
  output mrpasm_pkg::res_t               res_o
);

  mrpasm_pkg::cmd_e   eff;
  mrpasm_pkg::app_e   a;
  mrpasm_pkg::reg_e   r;
  mrpasm_pkg::entry_t nxt;
  mrpasm_pkg::txev_e  txe;
  logic               txv;
  logic               jind;
  logic               jnew;

  // Encode the attribute event sent from a given applicant state
  function automatic mrpasm_pkg::txev_e tx_code(mrpasm_pkg::app_e app,
                                                mrpasm_pkg::reg_e rg,
                                                logic la);
    mrpasm_pkg::txev_e ev;
    ev = mrpasm_pkg::EV_NEW;
    case (app) inside
      mrpasm_pkg::APP_VP, mrpasm_pkg::APP_AA, mrpasm_pkg::APP_AP,
      mrpasm_pkg::APP_QA, mrpasm_pkg::APP_QP: begin
        if (la && app == mrpasm_pkg::APP_VP) begin
          ev = (rg == mrpasm_pkg::REG_IN) ? mrpasm_pkg::EV_IN : mrpasm_pkg::EV_MT;
        end else if (la || app != mrpasm_pkg::APP_QP) begin
          ev = (rg == mrpasm_pkg::REG_IN) ? mrpasm_pkg::EV_JOININ : mrpasm_pkg::EV_JOINMT;
        end else begin
          ev = mrpasm_pkg::EV_NEW;
        end
      end
      mrpasm_pkg::APP_VN, mrpasm_pkg::APP_AN: ev = mrpasm_pkg::EV_NEW;
      mrpasm_pkg::APP_LA: ev = mrpasm_pkg::EV_LV;
      mrpasm_pkg::APP_LO: begin
        ev = (rg == mrpasm_pkg::REG_IN) ? mrpasm_pkg::EV_IN : mrpasm_pkg::EV_MT;
      end
      default: ev = mrpasm_pkg::EV_NEW;
    endcase
    return ev;
  endfunction

  always_comb begin
    nxt  = cur_i;
    a    = cur_i.applicant;
    r    = cur_i.registrar;
    txv  = 1'b0;
    txe  = mrpasm_pkg::EV_NEW;
    jind = 1'b0;
    jnew = 1'b0;
    eff  = mrpasm_pkg::cmd_e'(cmd_i);

    // Advance the leave timer; expiry turns the tick into a leave timer event
    if (eff == mrpasm_pkg::CMD_TICK && cur_i.leave_active) begin
      if (cur_i.leave_count <= mrpasm_pkg::LEAVE_W'(1)) begin
        nxt.leave_count  = '0;
        nxt.leave_active = 1'b0;
        eff              = mrpasm_pkg::CMD_LEAVETIMER;
      end else begin
        nxt.leave_count = cur_i.leave_count - mrpasm_pkg::LEAVE_W'(1);
      end
    end

    // Registrar machine
    case (eff) inside
      mrpasm_pkg::CMD_BEGIN: begin
        r                = mrpasm_pkg::REG_MT;
        nxt.leave_active = 1'b0;
        nxt.leave_count  = '0;
      end
      mrpasm_pkg::CMD_RNEW: begin
        if (r == mrpasm_pkg::REG_LV) nxt.leave_active = 1'b0;
        r    = mrpasm_pkg::REG_IN;
        jind = 1'b1;
        jnew = 1'b1;
      end
      mrpasm_pkg::CMD_RJOININ, mrpasm_pkg::CMD_RJOINMT: begin
        if (r == mrpasm_pkg::REG_LV) nxt.leave_active = 1'b0;
        if (r == mrpasm_pkg::REG_MT) jind = 1'b1;
        r = mrpasm_pkg::REG_IN;
      end
      mrpasm_pkg::CMD_RLV, mrpasm_pkg::CMD_RLA, mrpasm_pkg::CMD_TXLA,
      mrpasm_pkg::CMD_REDECLARE: begin
        if (r == mrpasm_pkg::REG_IN) begin
          nxt.leave_count  = leave_period_i;
          nxt.leave_active = 1'b1;
          r                = mrpasm_pkg::REG_LV;
        end
      end
      mrpasm_pkg::CMD_FLUSH, mrpasm_pkg::CMD_LEAVETIMER: r = mrpasm_pkg::REG_MT;
      default: ;
    endcase

    // Applicant machine
    case (eff) inside
      mrpasm_pkg::CMD_BEGIN: a = mrpasm_pkg::APP_VO;
      mrpasm_pkg::CMD_NEW:   a = mrpasm_pkg::APP_VN;
      mrpasm_pkg::CMD_JOIN: begin
        case (a) inside
          mrpasm_pkg::APP_VO, mrpasm_pkg::APP_LO: a = mrpasm_pkg::APP_VP;
          mrpasm_pkg::APP_LA: a = mrpasm_pkg::APP_AA;
          mrpasm_pkg::APP_AO: a = mrpasm_pkg::APP_AP;
          mrpasm_pkg::APP_QO: a = mrpasm_pkg::APP_QP;
          default: ;
        endcase
      end
      mrpasm_pkg::CMD_LV: begin
        case (a) inside
          mrpasm_pkg::APP_QP: a = mrpasm_pkg::APP_QO;
          mrpasm_pkg::APP_AP: a = mrpasm_pkg::APP_AO;
          mrpasm_pkg::APP_VP: a = mrpasm_pkg::APP_VO;
          mrpasm_pkg::APP_VN, mrpasm_pkg::APP_AN, mrpasm_pkg::APP_AA,
          mrpasm_pkg::APP_QA: a = mrpasm_pkg::APP_LA;
          default: ;
        endcase
      end
      mrpasm_pkg::CMD_RJOININ: begin
        case (a) inside
          mrpasm_pkg::APP_VO: a = mrpasm_pkg::APP_AO;
          mrpasm_pkg::APP_VP: a = mrpasm_pkg::APP_AP;
          mrpasm_pkg::APP_AA: a = mrpasm_pkg::APP_QA;
          mrpasm_pkg::APP_AO: a = mrpasm_pkg::APP_QO;
          mrpasm_pkg::APP_AP: a = mrpasm_pkg::APP_QP;
          default: ;
        endcase
      end
      mrpasm_pkg::CMD_RIN: begin
        if (a == mrpasm_pkg::APP_AA) a = mrpasm_pkg::APP_QA;
      end
      mrpasm_pkg::CMD_RJOINMT, mrpasm_pkg::CMD_RMT: begin
        case (a) inside
          mrpasm_pkg::APP_QA: a = mrpasm_pkg::APP_AA;
          mrpasm_pkg::APP_QO: a = mrpasm_pkg::APP_AO;
          mrpasm_pkg::APP_QP: a = mrpasm_pkg::APP_AP;
          mrpasm_pkg::APP_LO: a = mrpasm_pkg::APP_VO;
          default: ;
        endcase
      end
      mrpasm_pkg::CMD_RLV, mrpasm_pkg::CMD_RLA, mrpasm_pkg::CMD_REDECLARE: begin
        case (a) inside
          mrpasm_pkg::APP_VO, mrpasm_pkg::APP_AO, mrpasm_pkg::APP_QO: a = mrpasm_pkg::APP_LO;
          mrpasm_pkg::APP_AN: a = mrpasm_pkg::APP_VN;
          mrpasm_pkg::APP_AA, mrpasm_pkg::APP_QA, mrpasm_pkg::APP_AP,
          mrpasm_pkg::APP_QP: a = mrpasm_pkg::APP_VP;
          default: ;
        endcase
      end
      mrpasm_pkg::CMD_PERIODIC: begin
        if (a == mrpasm_pkg::APP_QA) a = mrpasm_pkg::APP_AA;
        else if (a == mrpasm_pkg::APP_QP) a = mrpasm_pkg::APP_AP;
      end
      mrpasm_pkg::CMD_TX: begin
        case (a) inside
          mrpasm_pkg::APP_VP, mrpasm_pkg::APP_VN, mrpasm_pkg::APP_AN,
          mrpasm_pkg::APP_AA, mrpasm_pkg::APP_LA, mrpasm_pkg::APP_AP,
          mrpasm_pkg::APP_LO: begin
            txv = 1'b1;
            txe = tx_code(a, r, 1'b0);
          end
          default: ;
        endcase
        case (a) inside
          mrpasm_pkg::APP_VP: a = mrpasm_pkg::APP_AA;
          mrpasm_pkg::APP_VN: a = mrpasm_pkg::APP_AN;
          mrpasm_pkg::APP_AN, mrpasm_pkg::APP_AA, mrpasm_pkg::APP_AP: a = mrpasm_pkg::APP_QA;
          mrpasm_pkg::APP_LA, mrpasm_pkg::APP_LO: a = mrpasm_pkg::APP_VO;
          default: ;
        endcase
      end
      mrpasm_pkg::CMD_TXLA: begin
        case (a) inside
          mrpasm_pkg::APP_VP, mrpasm_pkg::APP_VN, mrpasm_pkg::APP_AN,
          mrpasm_pkg::APP_AA, mrpasm_pkg::APP_LA, mrpasm_pkg::APP_QA,
          mrpasm_pkg::APP_AP, mrpasm_pkg::APP_QP: begin
            txv = 1'b1;
            txe = tx_code(a, r, 1'b1);
          end
          default: ;
        endcase
        case (a) inside
          mrpasm_pkg::APP_VO, mrpasm_pkg::APP_LA, mrpasm_pkg::APP_AO,
          mrpasm_pkg::APP_QO: a = mrpasm_pkg::APP_LO;
          mrpasm_pkg::APP_VN: a = mrpasm_pkg::APP_AN;
          mrpasm_pkg::APP_AN, mrpasm_pkg::APP_AA, mrpasm_pkg::APP_AP,
          mrpasm_pkg::APP_QP: a = mrpasm_pkg::APP_QA;
          default: ;
        endcase
      end
      default: ;
    endcase

    nxt.applicant = a;
    nxt.registrar = r;
  end

  assign nxt_o             = nxt;
  assign res_o.applicant   = a;
  assign res_o.registrar   = r;
  assign res_o.tx_valid    = txv;
  assign res_o.tx_attr     = txe;
  assign res_o.join_ind    = jind;
  assign res_o.join_is_new = jnew;

endmodule

/* rtl/mrpasm_sva.sv */
// Port-level checks for the MRP attribute state machine, bound to the top level.
module mrpasm_sva (
  input logic                                   clk_i,
  input logic                                   rst_ni,
  input logic                                   start,
  input logic                                   busy,
  input logic [mrpasm_pkg::INDEX_W-1:0]         entry_index_i,
  input logic                                   result_strobe_o,
  input logic                                   tx_valid_o,
  input logic [2:0]                             tx_attr_o,
  input logic                                   join_ind_o,
  input logic                                   join_is_new_o,
  input logic [mrpasm_pkg::INDEX_W-1:0]         entry_echo_o
);

  // Every accepted event is followed by a result beat once its update state has ended
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##2 result_strobe_o)
    else $error("result beat missing after accepted event");

  // A result beat only ever follows an accepted event
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> $past(busy) && !busy)
    else $error("result beat without an event in flight");

  // The echoed index is the one taken with the event
  a_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> entry_echo_o == $past(entry_index_i, 2))
    else $error("entry echo does not match accepted index");

  // No transmit code or new flag without their qualifiers
  a_quiet_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> (tx_valid_o || tx_attr_o == mrpasm_pkg::EV_NEW) &&
                        (join_ind_o || !join_is_new_o))
    else $error("qualified result field set without its valid");

endmodule

bind mrp_attribute_state_machine mrpasm_sva u_mrpasm_sva (.*);
